/* design/plna_pkg.sv */
package plna_pkg;

    // Fixed field widths of the ports
    localparam int OP_W       = 2;
    localparam int LVL_IN_W   = 4;
    localparam int IDX_W      = 14;
    localparam int CAP_W      = 11;
    localparam int BUMP_W     = 11;
    localparam int OUT_CNT_W  = 16;
    localparam int NODE_SPACE = 16384;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Defaults for the top-level parameters
    localparam int LEVELS_DEF          = 16;
    localparam int SLOTS_PER_LEVEL_DEF = 1024;
    localparam int COUNT_BITS_DEF      = 16;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_DROP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_LINK
    } t_state;

    typedef struct packed {
        logic load;    // capture the input transaction
        logic clear;   // write one entry of the clearing pass
        logic commit;  // finish the transaction from the first memory read
        logic pop;     // finish an allocate from the free stack
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic need_pop;
        logic out_free;
    } t_sts;

endpackage

/* design/plna_ram.sv */
module plna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/plna_ctrl.sv */
module plna_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  plna_pkg::t_sts  i_sts,
    output logic            o_stall,
    output plna_pkg::t_cmd  o_cmd
);
    import plna_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (i_sts.need_pop) begin
                    n_state = S_LINK;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_ADDR: begin
            end
            S_DATA: begin
                o_cmd.commit = !i_sts.need_pop && i_sts.out_free;
            end
            S_LINK: begin
                o_cmd.pop = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/plna_dp.sv */
module plna_dp #(
    parameter int LEVELS          = plna_pkg::LEVELS_DEF,
    parameter int SLOTS_PER_LEVEL = plna_pkg::SLOTS_PER_LEVEL_DEF,
    parameter int COUNT_BITS      = plna_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  plna_pkg::t_cmd                 i_cmd,
    output plna_pkg::t_sts                 o_sts,
    input  logic [plna_pkg::OP_W-1:0]      i_op,
    input  logic [plna_pkg::LVL_IN_W-1:0]  i_level,
    input  logic [plna_pkg::IDX_W-1:0]     i_node_index,
    input  logic                           i_cfg_we,
    input  logic [plna_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [plna_pkg::IDX_W-1:0]     o_result_index,
    output logic [1:0]                     o_status,
    output logic [plna_pkg::OUT_CNT_W-1:0] o_ref_count
);
    import plna_pkg::*;

    localparam int LVL_AW      = $clog2(LEVELS);
    localparam int NODE_AW     = $clog2(NODE_SPACE);
    localparam int DEPTH_W     = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int LVL_WORD_W  = IDX_W + DEPTH_W + BUMP_W;
    localparam int NODE_WORD_W = COUNT_BITS + 1;
    localparam int BASE_W      = LVL_IN_W + $clog2(SLOTS_PER_LEVEL + 1);
    localparam int SUM_W       = ((BASE_W > BUMP_W) ? BASE_W : BUMP_W) + 1;
    // node / SLOTS_PER_LEVEL as a multiply by a rounded-up reciprocal,
    // exact for every IDX_W-bit node index
    localparam int DIV_SH      = IDX_W + $clog2(SLOTS_PER_LEVEL);
    localparam int MUL_W       = IDX_W + 2;
    localparam int PROD_W      = IDX_W + MUL_W;
    localparam longint DIV_MUL =
        ((longint'(1) << DIV_SH) + longint'(SLOTS_PER_LEVEL) - 1) / SLOTS_PER_LEVEL;
    localparam logic [MUL_W-1:0] DIV_M = MUL_W'(DIV_MUL);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration
    logic [CAP_W-1:0] r_level_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_level_capacity <= i_cfg_wdata;
        end
    end

    // Transaction registers
    t_op                 r_op;
    logic [LVL_IN_W-1:0] r_level;
    logic                r_lvl_ok;
    logic [IDX_W-1:0]    r_node;
    logic [BASE_W-1:0]   r_base;
    logic [IDX_W-1:0]    r_home;
    logic [PROD_W-1:0]   w_prod;

    assign w_prod = PROD_W'(i_node_index) * PROD_W'(DIV_M);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_level  <= i_level;
            r_lvl_ok <= int'(i_level) < LEVELS;
            r_node   <= i_node_index;
            r_base   <= BASE_W'(int'(i_level) * SLOTS_PER_LEVEL);
            r_home   <= IDX_W'(w_prod >> DIV_SH);
        end
    end

    // Clearing pass counter
    logic [NODE_AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Memories
    logic                   lvl_we;
    logic [LVL_AW-1:0]      lvl_waddr;
    logic [LVL_AW-1:0]      lvl_addr;
    logic [LVL_WORD_W-1:0]  lvl_wdata;
    logic [LVL_WORD_W-1:0]  lvl_q;
    logic                   node_we;
    logic [NODE_AW-1:0]     node_waddr;
    logic [NODE_WORD_W-1:0] node_wdata;
    logic [NODE_WORD_W-1:0] node_q;
    logic                   link_we;
    logic [IDX_W-1:0]       link_q;

    logic [IDX_W-1:0]      lq_head;
    logic [DEPTH_W-1:0]    lq_depth;
    logic [BUMP_W-1:0]     lq_bump;
    logic                  nq_live;
    logic [COUNT_BITS-1:0] nq_count;

    assign lq_head  = lvl_q[LVL_WORD_W-1 -: IDX_W];
    assign lq_depth = lvl_q[BUMP_W +: DEPTH_W];
    assign lq_bump  = lvl_q[BUMP_W-1:0];
    assign nq_live  = node_q[COUNT_BITS];
    assign nq_count = node_q[COUNT_BITS-1:0];

    assign lvl_addr = (r_op == OP_ALLOC) ? LVL_AW'(r_level) : LVL_AW'(r_home);

    plna_ram #(.WIDTH(LVL_WORD_W), .DEPTH(LEVELS)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_addr),
        .o_rdata (lvl_q)
    );

    plna_ram #(.WIDTH(NODE_WORD_W), .DEPTH(NODE_SPACE)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (r_node),
        .o_rdata (node_q)
    );

    plna_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SPACE)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_node),
        .i_wdata (lq_head),
        .i_raddr (lq_head),
        .o_rdata (link_q)
    );

    // Decisions, valid while the read data is up
    logic [CAP_W-1:0]  w_cap;
    logic [SUM_W-1:0]  w_wide;
    logic              w_is_alloc;
    logic              w_need_pop;
    logic              w_bump_ok;
    logic              w_free_ok;
    logic              w_add_ok;
    logic              w_drop_ok;

    assign w_cap = (int'(r_level_capacity) > SLOTS_PER_LEVEL) ?
                   CAP_W'(SLOTS_PER_LEVEL) : r_level_capacity;
    assign w_wide = SUM_W'(r_base) + SUM_W'(lq_bump);

    assign w_is_alloc = (r_op == OP_ALLOC);
    assign w_need_pop = w_is_alloc && r_lvl_ok && (lq_depth != '0);
    assign w_bump_ok  = w_is_alloc && r_lvl_ok && (lq_depth == '0) &&
                        (lq_bump < w_cap) && (int'(w_wide) < NODE_SPACE);
    assign w_free_ok  = (r_op == OP_FREE) && (int'(r_home) < LEVELS) && nq_live;
    assign w_add_ok   = (r_op == OP_ADD) && (nq_count != CNT_MAX);
    assign w_drop_ok  = (r_op == OP_DROP) && (nq_count != '0);

    // Memory writes
    always_comb begin
        lvl_we     = 1'b0;
        lvl_waddr  = lvl_addr;
        lvl_wdata  = lvl_q;
        node_we    = 1'b0;
        node_waddr = r_node;
        node_wdata = node_q;
        link_we    = 1'b0;
        if (i_cmd.clear) begin
            lvl_we     = int'(r_clr_cnt) < LEVELS;
            lvl_waddr  = LVL_AW'(r_clr_cnt);
            lvl_wdata  = '0;
            node_we    = 1'b1;
            node_waddr = r_clr_cnt;
            node_wdata = '0;
        end else if (i_cmd.pop) begin
            lvl_we     = 1'b1;
            lvl_wdata  = {link_q, lq_depth - 1'b1, lq_bump};
            node_we    = 1'b1;
            node_waddr = lq_head;
            node_wdata = {1'b1, {COUNT_BITS{1'b0}}};
        end else if (i_cmd.commit) begin
            if (w_bump_ok) begin
                lvl_we     = 1'b1;
                lvl_wdata  = {lq_head, lq_depth, lq_bump + 1'b1};
                node_we    = 1'b1;
                node_waddr = NODE_AW'(w_wide);
                node_wdata = {1'b1, {COUNT_BITS{1'b0}}};
            end else if (w_free_ok) begin
                lvl_we     = 1'b1;
                lvl_wdata  = {r_node, lq_depth + 1'b1, lq_bump};
                node_we    = 1'b1;
                node_wdata = {1'b0, nq_count};
                link_we    = 1'b1;
            end else if (w_add_ok) begin
                node_we    = 1'b1;
                node_wdata = {nq_live, nq_count + 1'b1};
            end else if (w_drop_ok) begin
                node_we    = 1'b1;
                node_wdata = {nq_live, nq_count - 1'b1};
            end
        end
    end

    // Result register
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_res_idx;
    t_status              r_status;
    logic [OUT_CNT_W-1:0] r_count;
    logic [IDX_W-1:0]     n_res_idx;
    t_status              n_status;
    logic [OUT_CNT_W-1:0] n_count;

    always_comb begin
        n_res_idx = r_node;
        n_status  = ST_OK;
        n_count   = '0;
        if (i_cmd.pop) begin
            n_res_idx = lq_head;
        end else begin
            case (r_op)
                OP_ALLOC: begin
                    if (w_bump_ok) begin
                        n_res_idx = IDX_W'(w_wide);
                    end else begin
                        n_status = ST_NO_SPACE;
                    end
                end
                OP_FREE: begin
                    if (w_free_ok) begin
                        n_count = OUT_CNT_W'(nq_count);
                    end
                end
                OP_ADD: begin
                    if (w_add_ok) begin
                        n_count = OUT_CNT_W'(nq_count + 1'b1);
                    end else begin
                        n_status = ST_OVERFLOW;
                        n_count  = OUT_CNT_W'(nq_count);
                    end
                end
                OP_DROP: begin
                    if (w_drop_ok) begin
                        n_count = OUT_CNT_W'(nq_count - 1'b1);
                    end else begin
                        n_status = ST_UNDERFLOW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.pop) begin
            r_res_idx <= n_res_idx;
            r_status  <= n_status;
            r_count   <= n_count;
        end
    end

    assign o_sts.clr_done = (r_clr_cnt == NODE_AW'(NODE_SPACE - 1));
    assign o_sts.need_pop = w_need_pop;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_result_index = r_res_idx;
    assign o_status       = r_status;
    assign o_ref_count    = r_count;

endmodule

/* design/per_level_node_allocator_refcount.sv */
// Channel   Direction  Handshake          Payload
// in        sink       i_valid / o_stall  i_op, i_level, i_node_index
// out       source     o_valid / i_stall  o_result_index, o_status, o_ref_count
// cfg       sink       i_cfg_we           i_cfg_wdata (level capacity)
//
// One transaction at a time: after an accept the block passes an address step
// and a data step; a free-stack allocate adds a link step (level memory read,
// then link memory read). After reset a clearing pass zeroes the node and level
// memories; o_stall stays high meanwhile, configuration writes still land.
// A result waiting on i_stall holds the block in its final step.
module per_level_node_allocator_refcount #(
    parameter int LEVELS          = plna_pkg::LEVELS_DEF,
    parameter int SLOTS_PER_LEVEL = plna_pkg::SLOTS_PER_LEVEL_DEF,
    parameter int COUNT_BITS      = plna_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [plna_pkg::OP_W-1:0]      i_op,
    input  logic [plna_pkg::LVL_IN_W-1:0]  i_level,
    input  logic [plna_pkg::IDX_W-1:0]     i_node_index,
    input  logic                           i_cfg_we,
    input  logic [plna_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [plna_pkg::IDX_W-1:0]     o_result_index,
    output logic [1:0]                     o_status,
    output logic [plna_pkg::OUT_CNT_W-1:0] o_ref_count
);
    import plna_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    plna_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    plna_dp #(
        .LEVELS          (LEVELS),
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
        .COUNT_BITS      (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_op),
        .i_level        (i_level),
        .i_node_index   (i_node_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_index (o_result_index),
        .o_status       (o_status),
        .o_ref_count    (o_ref_count)
    );

endmodule
